>>> src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Types, codes and constants shared by the serial bank mapper files.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Field widths of one access word and one result word
  localparam int unsigned CmdW    = 2;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned TgtW    = 2;
  localparam int unsigned OffsW   = 18;
  localparam int unsigned MirrorW = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BanksW   = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PRG_ROM_BANKS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHR_IS_RAM    = 2'd1;

  // Reset values
  localparam logic [BanksW-1:0]  PrgBanksReset = 5'd2;
  localparam logic [4:0]         CtrlReset     = 5'h1c;

  typedef enum logic [CmdW-1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_VID_RD = 2'd2,
    CMD_VID_WR = 2'd3
  } cmd_e;

  typedef enum logic [TgtW-1:0] {
    TGT_NONE   = 2'd0,
    TGT_SRAM   = 2'd1,
    TGT_PRGROM = 2'd2,
    TGT_VIDEO  = 2'd3
  } target_e;

  typedef enum logic [MirrorW-1:0] {
    MIR_SINGLE_LO = 2'd0,
    MIR_SINGLE_HI = 2'd1,
    MIR_VERTICAL  = 2'd2,
    MIR_HORIZ     = 2'd3
  } mirror_e;

  // Serial load target, chosen by address bits 14:13
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_VID_LO  = 2'd1,
    SEL_VID_HI  = 2'd2,
    SEL_PROGRAM = 2'd3
  } load_sel_e;

  // Program banking mode, control bits 3:2
  typedef enum logic [1:0] {
    PRG_32K_A    = 2'd0,
    PRG_32K_B    = 2'd1,
    PRG_FIX_LOW  = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } prg_mode_e;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_byte;
  } access_t;

  typedef struct packed {
    target_e          mem_target;
    logic [OffsW-1:0] mem_offset;
    logic             mem_write;
    logic [DataW-1:0] pass_data;
    logic             accepted;
    mirror_e          mirroring;
  } result_t;

  // Bank state seen by the translation logic
  typedef struct packed {
    logic             chr_is_ram;
    logic [4:0]       control;
    logic [4:0]       vid_lo4k;
    logic [4:0]       vid_hi4k;
    logic [3:0]       vid_8k;
    logic [2:0]       prg_32k;
    logic [3:0]       prg_lo16k;
    logic [3:0]       prg_hi16k;
  } bank_state_t;

endpackage

>>> src/sbm_access_if.sv
// ----------------------------------------------------------------------------
// sbm_access_if
// Valid/ready channel carrying one bus access word.
// ----------------------------------------------------------------------------
interface sbm_access_if import sbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_byte;

  modport source (output valid, command, address, write_byte, input ready);
  modport sink   (input valid, command, address, write_byte, output ready);
endinterface

>>> src/sbm_result_if.sv
// ----------------------------------------------------------------------------
// sbm_result_if
// Valid/ready channel carrying one translated access word.
// ----------------------------------------------------------------------------
interface sbm_result_if import sbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TgtW-1:0]    mem_target;
  logic [OffsW-1:0]   mem_offset;
  logic               mem_write;
  logic [DataW-1:0]   pass_data;
  logic               accepted;
  logic [MirrorW-1:0] mirroring;

  modport source (output valid, mem_target, mem_offset, mem_write, pass_data,
                  accepted, mirroring, input ready);
  modport sink   (input valid, mem_target, mem_offset, mem_write, pass_data,
                  accepted, mirroring, output ready);
endinterface

>>> src/sbm_cfg_if.sv
// ----------------------------------------------------------------------------
// sbm_cfg_if
// Valid/ready configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbm_cfg_if import sbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sbm_bank_regs.sv
// ----------------------------------------------------------------------------
// sbm_bank_regs
// Serial load register, control and bank registers, configuration registers.
// ----------------------------------------------------------------------------
module sbm_bank_regs import sbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  access_t             item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output bank_state_t         state_o,
  output mirror_e             mirror_next_o
);

  logic [BanksW-1:0] banks_q, banks_d;
  logic              chr_ram_q, chr_ram_d;
  logic [4:0]        shift_q, shift_d;
  logic [2:0]        count_q, count_d;
  logic [4:0]        ctrl_q, ctrl_d;
  logic [4:0]        vlo_q, vlo_d;
  logic [4:0]        vhi_q, vhi_d;
  logic [3:0]        v8k_q, v8k_d;
  logic [2:0]        p32_q, p32_d;
  logic [3:0]        plo_q, plo_d;
  logic [3:0]        phi_q, phi_d;
  mirror_e           mir_q, mir_d;

  logic [BanksW-1:0] banks_m1;
  logic [BanksW-1:0] new_banks_m1;
  logic [4:0]        shifted;
  logic              reg_write;

  assign banks_m1     = banks_q - BanksW'(1);
  assign new_banks_m1 = cfg_data_i[BanksW-1:0] - BanksW'(1);
  assign shifted      = {item_i.write_byte[0], shift_q[4:1]};
  assign reg_write    = step_i && (item_i.command == CMD_CPU_WR) && item_i.address[15];

  // Next state: config writes, reset byte, serial shift and register load
  always_comb begin
    banks_d   = banks_q;
    chr_ram_d = chr_ram_q;
    shift_d   = shift_q;
    count_d   = count_q;
    ctrl_d    = ctrl_q;
    vlo_d     = vlo_q;
    vhi_d     = vhi_q;
    v8k_d     = v8k_q;
    p32_d     = p32_q;
    plo_d     = plo_q;
    phi_d     = phi_q;
    mir_d     = mir_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRG_ROM_BANKS: begin
          banks_d = cfg_data_i[BanksW-1:0];
          phi_d   = new_banks_m1[3:0];
        end
        REG_CHR_IS_RAM: chr_ram_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (reg_write) begin
      if (item_i.write_byte[7]) begin
        shift_d    = '0;
        count_d    = '0;
        ctrl_d     = ctrl_q | 5'h0c;
      end else if (count_q == 3'd4) begin
        shift_d = '0;
        count_d = '0;
        unique case (load_sel_e'(item_i.address[14:13]))
          SEL_CONTROL: begin
            ctrl_d = shifted;
            mir_d  = mirror_e'(shifted[1:0]);
          end
          SEL_VID_LO: begin
            if (ctrl_q[4]) begin
              vlo_d = shifted;
            end else begin
              v8k_d = shifted[4:1];
            end
          end
          SEL_VID_HI: begin
            if (ctrl_q[4]) begin
              vhi_d = shifted;
            end
          end
          SEL_PROGRAM: begin
            unique case (prg_mode_e'(ctrl_q[3:2]))
              PRG_32K_A, PRG_32K_B: p32_d = shifted[3:1];
              PRG_FIX_LOW: begin
                plo_d = '0;
                phi_d = shifted[3:0];
              end
              PRG_FIX_HIGH: begin
                plo_d = shifted[3:0];
                phi_d = banks_m1[3:0];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end else begin
        shift_d = shifted;
        count_d = count_q + 3'd1;
      end
    end
  end

  // Hold state between accesses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_q   <= PrgBanksReset;
      chr_ram_q <= 1'b0;
      shift_q   <= '0;
      count_q   <= '0;
      ctrl_q    <= CtrlReset;
      vlo_q     <= '0;
      vhi_q     <= '0;
      v8k_q     <= '0;
      p32_q     <= '0;
      plo_q     <= '0;
      phi_q     <= 4'(PrgBanksReset - BanksW'(1));
      mir_q     <= MIR_HORIZ;
    end else begin
      banks_q   <= banks_d;
      chr_ram_q <= chr_ram_d;
      shift_q   <= shift_d;
      count_q   <= count_d;
      ctrl_q    <= ctrl_d;
      vlo_q     <= vlo_d;
      vhi_q     <= vhi_d;
      v8k_q     <= v8k_d;
      p32_q     <= p32_d;
      plo_q     <= plo_d;
      phi_q     <= phi_d;
      mir_q     <= mir_d;
    end
  end

  assign state_o.chr_is_ram = chr_ram_q;
  assign state_o.control    = ctrl_q;
  assign state_o.vid_lo4k   = vlo_q;
  assign state_o.vid_hi4k   = vhi_q;
  assign state_o.vid_8k     = v8k_q;
  assign state_o.prg_32k    = p32_q;
  assign state_o.prg_lo16k  = plo_q;
  assign state_o.prg_hi16k  = phi_q;
  assign mirror_next_o      = mir_d;

endmodule

>>> src/sbm_translate.sv
// ----------------------------------------------------------------------------
// sbm_translate
// Maps one bus access onto its target memory and banked byte offset.
// ----------------------------------------------------------------------------
module sbm_translate import sbm_pkg::*; (
  input  access_t     item_i,
  input  bank_state_t state_i,
  input  mirror_e     mirror_i,
  output result_t     res_o
);

  logic [12:0] vaddr;
  logic [3:0]  prg_bank;
  logic [4:0]  vid_bank;

  assign vaddr    = item_i.address[12:0];
  assign prg_bank = item_i.address[14] ? state_i.prg_hi16k : state_i.prg_lo16k;
  assign vid_bank = vaddr[12] ? state_i.vid_hi4k : state_i.vid_lo4k;

  // Decode the command and bank the address
  always_comb begin
    res_o.mem_target = TGT_NONE;
    res_o.mem_offset = '0;
    res_o.mem_write  = 1'b0;
    res_o.pass_data  = '0;
    res_o.accepted   = 1'b1;
    res_o.mirroring  = mirror_i;

    case (item_i.command)
      CMD_CPU_RD, CMD_CPU_WR: begin
        if (!item_i.address[15]) begin
          res_o.mem_target = TGT_SRAM;
          res_o.mem_offset = OffsW'(item_i.address[12:0]);
          if (item_i.command == CMD_CPU_WR) begin
            res_o.mem_write = 1'b1;
            res_o.pass_data = item_i.write_byte;
          end
        end else if (item_i.command == CMD_CPU_RD) begin
          res_o.mem_target = TGT_PRGROM;
          if (state_i.control[3]) begin
            res_o.mem_offset = {prg_bank, item_i.address[13:0]};
          end else begin
            res_o.mem_offset = {state_i.prg_32k, item_i.address[14:0]};
          end
        end
      end
      default: begin
        res_o.mem_target = TGT_VIDEO;
        if (state_i.chr_is_ram) begin
          res_o.mem_offset = OffsW'(vaddr);
          if (item_i.command == CMD_VID_WR) begin
            res_o.mem_write = 1'b1;
            res_o.pass_data = item_i.write_byte;
          end
        end else if (item_i.command == CMD_VID_WR) begin
          res_o.accepted = 1'b0;
        end else if (state_i.control[4]) begin
          res_o.mem_offset = OffsW'({vid_bank, vaddr[11:0]});
        end else begin
          res_o.mem_offset = OffsW'({state_i.vid_8k, vaddr});
        end
      end
    endcase
  end

endmodule

>>> src/serial_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// serial_bank_mapper_top
// Serially loaded bank mapper: translates processor and video bus accesses.
//
//   Channel  Dir  Word contents
//   in_i     in   command, address, write_byte
//   out_o    out  mem_target, mem_offset, mem_write, pass_data, accepted,
//                 mirroring
//   cfg_i    in   index, data (0 prg_rom_banks, 1 chr_is_ram)
//
// One access word per cycle sustained while out_o does not stall; the word
// sits in the input register, then moves into the result register, whose
// contents are on out_o. Reset returns all bank state to power-up values and
// needs no clearing pass. A stall on out_o holds the result register and then
// the input register; in_i stays ready while the input register can drain.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module serial_bank_mapper_top import sbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  sbm_access_if.sink         in_i,
  sbm_result_if.source       out_o,
  sbm_cfg_if.sink            cfg_i
);

  logic        in_vld_q;
  access_t     in_q;
  logic        out_vld_q;
  result_t     out_q;
  logic        advance;
  bank_state_t state;
  mirror_e     mirror_next;
  result_t     res;

  // Advance the input word when the result register is free or draining
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  sbm_bank_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .state_o       (state),
    .mirror_next_o (mirror_next)
  );

  sbm_translate u_xlate (
    .item_i   (in_q),
    .state_i  (state),
    .mirror_i (mirror_next),
    .res_o    (res)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= access_t'{command:    cmd_e'(in_i.command),
                        address:    in_i.address,
                        write_byte: in_i.write_byte};
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.mem_target = out_q.mem_target;
  assign out_o.mem_offset = out_q.mem_offset;
  assign out_o.mem_write  = out_q.mem_write;
  assign out_o.pass_data  = out_q.pass_data;
  assign out_o.accepted   = out_q.accepted;
  assign out_o.mirroring  = out_q.mirroring;

endmodule
